FILE: src/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg: shared definitions of the 3x3 median filter
// Register indexes, reset values, result queue sizing and the queue entry type.
// ----------------------------------------------------------------------------
package mf3_pkg;

   localparam int MAX_WIDTH_DEFAULT = 2048;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_COUNT  = 2'd2;

   localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd480;
   localparam logic [2:0]  PLANE_COUNT_RESET  = 3'd3;

   // Result queue depth; must be a power of two.
   localparam int RSP_DEPTH = 4;

   typedef logic [7:0] pixel_type;

   // One column of the window, sorted from smallest to largest.
   typedef struct packed {
      pixel_type lo;
      pixel_type mid;
      pixel_type hi;
   } column_type;

   // All results caused by one request: the delayed median and the border pixel.
   typedef struct packed {
      logic        med_en;
      pixel_type   med_value;
      logic        brd_en;
      pixel_type   brd_value;
      logic [1:0]  plane;
      logic [15:0] row;
      logic [10:0] column;
      logic        last;
   } rsp_entry_type;

endpackage

FILE: src/median_filter_3x3_top.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_top: streaming 3x3 median filter for planar 8-bit images
// Border pixels pass through, interior pixels become the median of their
// 3x3 neighborhood.
// ----------------------------------------------------------------------------
// The filter takes one pixel request per clock while the result queue has a
// free slot for it, in raster order, plane after plane, and gives at most one
// result per clock. A request passes through the line store read, a column
// sort stage and a median stage into the result queue, from which its first
// result is presented on the rsp port. Pixels that cause two results (those
// from row 2 and column 2 onwards in the last column or the last row) keep
// their queue slot until both results are taken, which paces input there.
// The two previous rows live in two RAMs of MAX_WIDTH entries with no
// clearing pass: their contents only count once written in the current plane.
// Any frame register write restarts the stream at plane 0, row 0, column 0.
module median_filter_3x3_top
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_pixel_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_out_plane,
   output logic [15:0]            rsp_out_row,
   output logic [10:0]            rsp_out_column,
   output logic [7:0]             rsp_filtered_value,
   output logic                   rsp_is_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = PTR_W + 1;
   localparam int SUM_W = PTR_W + 2;

   function automatic pixel_type max2(input pixel_type a, input pixel_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pixel_type min2(input pixel_type a, input pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pixel_type med3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic column_type sort3(input pixel_type a, input pixel_type b,
                                        input pixel_type c);
      column_type s;
      s.lo  = min2(min2(a, b), c);
      s.hi  = max2(max2(a, b), c);
      s.mid = med3(a, b, c);
      return s;
   endfunction

   // Configuration registers and position counters
   logic [11:0]      frame_width_ff;
   logic [15:0]      frame_height_ff;
   logic [2:0]       plane_count_ff;
   logic [COL_W-1:0] col_ff;
   logic [15:0]      row_ff;
   logic [1:0]       plane_ff;

   logic [15:0] width_eff;
   logic [15:0] height_eff;
   logic [2:0]  planes_eff;
   logic        last_col;
   logic        last_row;
   logic        last_plane;
   logic        req_fire;

   // Stage 1: line store data arrives
   logic             s1_valid_ff;
   pixel_type        s1_px_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [15:0]      s1_row_ff;
   logic [1:0]       s1_plane_ff;
   logic             s1_med_en_ff;
   logic             s1_brd_en_ff;
   logic             s1_last_ff;
   logic             s1_byp_ff;
   pixel_type        s1_byp_up_ff;
   pixel_type        s1_byp_lo_ff;
   pixel_type        upper_rdata;
   pixel_type        lower_rdata;
   pixel_type        s1_up;
   pixel_type        s1_lo;
   column_type       s1_new_col;
   column_type       win_col0_ff;
   column_type       win_col1_ff;

   // Stage 2: median of the three column aggregates
   logic          s2_valid_ff;
   pixel_type     s2_lo_ff;
   pixel_type     s2_mid_ff;
   pixel_type     s2_hi_ff;
   rsp_entry_type s2_entry_ff;
   rsp_entry_type s2_entry;
   logic          s2_push;

   // Result queue
   rsp_entry_type    rsp_mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [SUM_W-1:0] reserved;
   logic             phase_ff;
   rsp_entry_type    head;
   logic             show_med;
   logic             rsp_fire;
   logic             rsp_pop;

   always_comb begin
      width_eff = 16'(frame_width_ff);
      if (frame_width_ff == 12'd0) begin
         width_eff = 16'd1;
      end else if (16'(frame_width_ff) > 16'(MAX_WIDTH)) begin
         width_eff = 16'(MAX_WIDTH);
      end
      height_eff = (frame_height_ff == 16'd0) ? 16'd1 : frame_height_ff;
      planes_eff = plane_count_ff;
      if (plane_count_ff == 3'd0) begin
         planes_eff = 3'd1;
      end else if (plane_count_ff > 3'd4) begin
         planes_eff = 3'd4;
      end
   end

   assign last_col   = (17'(col_ff) + 17'd1) >= 17'(width_eff);
   assign last_row   = (17'(row_ff) + 17'd1) >= 17'(height_eff);
   assign last_plane = (3'(plane_ff) + 3'd1) >= planes_eff;

   // Every request already in flight holds a queue slot until it is pushed.
   assign reserved  = SUM_W'(count_ff) + SUM_W'(s1_valid_ff) + SUM_W'(s2_valid_ff);
   assign req_ready = reserved < SUM_W'(RSP_DEPTH);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         plane_count_ff  <= PLANE_COUNT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         plane_ff        <= '0;
      end else begin
         if (req_fire) begin
            if (last_col) begin
               col_ff <= '0;
               if (last_row) begin
                  row_ff   <= '0;
                  plane_ff <= last_plane ? 2'd0 : plane_ff + 2'd1;
               end else begin
                  row_ff <= row_ff + 16'd1;
               end
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH: begin
                  frame_width_ff <= csr_wdata[11:0];
                  col_ff   <= '0;
                  row_ff   <= '0;
                  plane_ff <= '0;
               end
               CSR_FRAME_HEIGHT: begin
                  frame_height_ff <= csr_wdata;
                  col_ff   <= '0;
                  row_ff   <= '0;
                  plane_ff <= '0;
               end
               CSR_PLANE_COUNT: begin
                  plane_count_ff <= csr_wdata[2:0];
                  col_ff   <= '0;
                  row_ff   <= '0;
                  plane_ff <= '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // The line stores are written by stage 1 at the same edge as the next read.
   mf3_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_lo),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (upper_rdata)
   );

   mf3_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_lower_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_px_ff),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (lower_rdata)
   );

   // A one-pixel-wide frame reads the column that is written in the same cycle.
   assign s1_up = s1_byp_ff ? s1_byp_up_ff : upper_rdata;
   assign s1_lo = s1_byp_ff ? s1_byp_lo_ff : lower_rdata;
   assign s1_new_col = sort3(s1_up, s1_lo, s1_px_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         win_col0_ff <= '0;
         win_col1_ff <= '0;
      end else begin
         s1_valid_ff <= req_fire;
         s2_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            win_col0_ff <= win_col1_ff;
            win_col1_ff <= s1_new_col;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_px_ff     <= req_pixel_value;
         s1_col_ff    <= col_ff;
         s1_row_ff    <= row_ff;
         s1_plane_ff  <= plane_ff;
         s1_med_en_ff <= (row_ff >= 16'd2) && (col_ff >= COL_W'(2));
         s1_brd_en_ff <= (row_ff == 16'd0) || last_row || (col_ff == '0) || last_col;
         s1_last_ff   <= last_row && last_col && last_plane;
         s1_byp_ff    <= s1_valid_ff && (s1_col_ff == col_ff);
         s1_byp_up_ff <= s1_lo;
         s1_byp_lo_ff <= s1_px_ff;
      end
      if (s1_valid_ff) begin
         s2_lo_ff  <= max2(max2(win_col0_ff.lo, win_col1_ff.lo), s1_new_col.lo);
         s2_mid_ff <= med3(win_col0_ff.mid, win_col1_ff.mid, s1_new_col.mid);
         s2_hi_ff  <= min2(min2(win_col0_ff.hi, win_col1_ff.hi), s1_new_col.hi);
         s2_entry_ff.med_en    <= s1_med_en_ff;
         s2_entry_ff.med_value <= '0;
         s2_entry_ff.brd_en    <= s1_brd_en_ff;
         s2_entry_ff.brd_value <= s1_px_ff;
         s2_entry_ff.plane     <= s1_plane_ff;
         s2_entry_ff.row       <= s1_row_ff;
         s2_entry_ff.column    <= 11'(s1_col_ff);
         s2_entry_ff.last      <= s1_last_ff;
      end
   end

   always_comb begin
      s2_entry           = s2_entry_ff;
      s2_entry.med_value = med3(s2_lo_ff, s2_mid_ff, s2_hi_ff);
   end

   assign s2_push = s2_valid_ff && (s2_entry_ff.med_en || s2_entry_ff.brd_en);

   // Result side: the median goes out first, then the border pass-through.
   assign head      = rsp_mem_ff[rd_ptr_ff];
   assign rsp_valid = count_ff != '0;
   assign show_med  = head.med_en && !phase_ff;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign rsp_pop   = rsp_fire && !(show_med && head.brd_en);

   assign rsp_out_plane      = head.plane;
   assign rsp_out_row        = show_med ? head.row - 16'd1 : head.row;
   assign rsp_out_column     = show_med ? head.column - 11'd1 : head.column;
   assign rsp_filtered_value = show_med ? head.med_value : head.brd_value;
   assign rsp_is_last        = show_med ? 1'b0 : head.last;

   always_ff @(posedge clock) begin
      if (s2_push) begin
         rsp_mem_ff[wr_ptr_ff] <= s2_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         if (s2_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (s2_push && !rsp_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (rsp_pop && !s2_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (rsp_fire) begin
            phase_ff <= !rsp_pop;
         end
      end
   end

   // The slot reservation must keep every in-flight request placeable.
   a_reserve_bound: assert property (@(posedge clock) disable iff (reset)
      reserved <= SUM_W'(RSP_DEPTH))
      else $error("result queue over-committed");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      s2_push |-> (count_ff < CNT_W'(RSP_DEPTH)) || rsp_pop)
      else $error("push into a full result queue");

   a_entry_has_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (head.med_en || head.brd_en))
      else $error("queued request without a result");

   a_phase_only_pairs: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (rsp_valid && head.med_en && head.brd_en))
      else $error("second-result phase on a single-result request");

   a_bypass_follows: assert property (@(posedge clock) disable iff (reset)
      s1_byp_ff && s1_valid_ff |-> $past(s1_valid_ff))
      else $error("line store bypass without a preceding write");

endmodule

FILE: src/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/sv/median_filter_3x3_checker.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_checker: result predictor and comparator for the median filter
// Follows register writes and pixel requests, works out the results each
// request causes and compares every result the filter hands out against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module median_filter_3x3_checker
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [7:0]             req_pixel_value,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [1:0]             rsp_out_plane,
   input  logic [15:0]            rsp_out_row,
   input  logic [10:0]            rsp_out_column,
   input  logic [7:0]             rsp_filtered_value,
   input  logic                   rsp_is_last,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     results_pending,
   output int                     results_checked
);

   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      logic [1:0]  plane;
      logic [15:0] row;
      logic [10:0] column;
      logic [7:0]  value;
      logic        last;
   } pixel_result_type;

   pixel_result_type expected_pixels [$];

   // Rows r-2 and r-1 of the current plane, indexed by column.
   logic [7:0] two_rows_up [MAX_WIDTH];
   logic [7:0] one_row_up [MAX_WIDTH];
   // Columns c-2 and c-1 of the neighborhood, oldest first.
   logic [7:0] window [6];

   logic [11:0] width_reg;
   logic [15:0] height_reg;
   logic [2:0]  planes_reg;
   int unsigned row_pos;
   int unsigned col_pos;
   int unsigned plane_pos;
   int          mismatches;
   int          checked;

   function automatic logic [7:0] median_of_nine(input logic [8:0][7:0] nb);
      int         below;
      int         not_above;
      logic [7:0] result;
      result = nb[0];
      for (int i = 0; i < 9; i++) begin
         below = 0;
         not_above = 0;
         for (int j = 0; j < 9; j++) begin
            if (nb[j] < nb[i]) below++;
            if (nb[j] <= nb[i]) not_above++;
         end
         // The fifth smallest has at most four values below it.
         if (below <= 4 && not_above > 4) result = nb[i];
      end
      return result;
   endfunction

   task automatic report_mismatch(input string text);
      if (mismatches < PRINT_LIMIT) $display("ERROR at %0t: %s", $time, text);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want,
                              input pixel_result_type at);
      if (got != want)
         report_mismatch($sformatf("%s is %0d, want %0d (plane %0d row %0d column %0d)",
                                   name, got, want, at.plane, at.row, at.column));
   endtask

   task automatic apply_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_FRAME_WIDTH: width_reg = data[11:0];
         CSR_FRAME_HEIGHT: height_reg = data[15:0];
         CSR_PLANE_COUNT: planes_reg = data[2:0];
         default: return;
      endcase
      row_pos = 0;
      col_pos = 0;
      plane_pos = 0;
   endtask

   task automatic predict_pixel(input logic [7:0] px);
      int unsigned     w;
      int unsigned     h;
      int unsigned     p;
      logic [7:0]      older;
      logic [7:0]      newer;
      logic [8:0][7:0] nb;
      logic            last;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg == 0) ? 1 : height_reg;
      p = (planes_reg == 0) ? 1 : (planes_reg > 4) ? 4 : planes_reg;
      older = two_rows_up[col_pos];
      newer = one_row_up[col_pos];

      // The arriving pixel completes the neighborhood of the pixel up and left.
      if (row_pos >= 2 && col_pos >= 2) begin
         nb = {px, newer, older, window[5], window[4], window[3],
               window[2], window[1], window[0]};
         expected_pixels.push_back('{plane: 2'(plane_pos), row: 16'(row_pos - 1),
                                     column: 11'(col_pos - 1),
                                     value: median_of_nine(nb), last: 1'b0});
      end

      for (int i = 0; i < 3; i++) window[i] = window[i + 3];
      window[3] = older;
      window[4] = newer;
      window[5] = px;
      two_rows_up[col_pos] = newer;
      one_row_up[col_pos] = px;

      if (row_pos == 0 || row_pos + 1 >= h || col_pos == 0 || col_pos + 1 >= w) begin
         last = (row_pos + 1 >= h) && (col_pos + 1 >= w) && (plane_pos + 1 >= p);
         expected_pixels.push_back('{plane: 2'(plane_pos), row: 16'(row_pos),
                                     column: 11'(col_pos), value: px, last: last});
      end

      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) begin
            row_pos = 0;
            plane_pos++;
            if (plane_pos >= p) plane_pos = 0;
         end
      end
   endtask

   task automatic check_result;
      pixel_result_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("result with none expected: plane %0d row %0d column %0d value %0d",
                                   rsp_out_plane, rsp_out_row, rsp_out_column,
                                   rsp_filtered_value));
      end else begin
         want = expected_pixels.pop_front();
         check_field("plane", rsp_out_plane, want.plane, want);
         check_field("row", rsp_out_row, want.row, want);
         check_field("column", rsp_out_column, want.column, want);
         check_field("value", rsp_filtered_value, want.value, want);
         check_field("last mark", rsp_is_last, want.last, want);
         checked++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg = FRAME_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         planes_reg = PLANE_COUNT_RESET;
         row_pos = 0;
         col_pos = 0;
         plane_pos = 0;
         for (int i = 0; i < 6; i++) window[i] = 8'd0;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_wdata);
         if (req_valid && req_ready) predict_pixel(req_pixel_value);
         if (rsp_valid && rsp_ready) check_result();
      end
      mismatch_count <= mismatches;
      results_pending <= expected_pixels.size();
      results_checked <= checked;
   end

endmodule

FILE: tb/sv/median_filter_3x3_top_tb.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_top_tb: stimulus and verdict for the 3x3 median filter
// Programs a series of frame geometries and streams pixel requests through the
// filter under changing back pressure; the checker beside the filter judges
// every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module median_filter_3x3_top_tb;
   import mf3_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int CONFIG_SETTLE = 8;
   localparam int END_SETTLE = 16;
   localparam int RANDOM_TARGET = 390;
   localparam int FRAME_CAP = 160;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef enum int {TEXTURE_NOISE, TEXTURE_FEW_LEVELS, TEXTURE_BLACK_WHITE} texture_type;

   // A bright diagonal cross on black: the neighborhood median of the center is 128.
   localparam logic [7:0] CROSS_PATTERN [9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd128,
                                                8'd0, 8'd255, 8'd0, 8'd255};
   localparam logic [7:0] WALKING_ONES [6] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
   localparam logic [7:0] PLANE_SAMPLES [5] = '{8'h40, 8'h80, 8'hAA, 8'h55, 8'hFF};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_pixel_value = 8'd0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_out_plane;
   logic [15:0]            rsp_out_row;
   logic [10:0]            rsp_out_column;
   logic [7:0]             rsp_filtered_value;
   logic                   rsp_is_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int mismatch_count;
   int results_pending;
   int results_checked;
   int stall_cycles = 0;
   int snd_idle_pct = 28;
   int rcv_idle_pct = 59;
   int pixels_sent = 0;
   int frame_setups = 0;

   always #6 clock = ~clock;

   median_filter_3x3_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel_value    (req_pixel_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_plane      (rsp_out_plane),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_column     (rsp_out_column),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_is_last        (rsp_is_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   median_filter_3x3_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel_value    (req_pixel_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_plane      (rsp_out_plane),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_column     (rsp_out_column),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_is_last        (rsp_is_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .results_pending    (results_pending),
      .results_checked    (results_checked)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [7:0] pick_pixel(input texture_type texture);
      case (texture)
         TEXTURE_FEW_LEVELS: return 8'($urandom_range(3) * 85);
         TEXTURE_BLACK_WHITE: return $urandom_range(1) ? 8'hFF : 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // The filter must be idle here: every frame register write restarts the stream.
   task automatic program_frame(input logic [15:0] width_data, input logic [15:0] height_data,
                                input logic [15:0] planes_data, input bit poke_spare);
      write_register(CSR_FRAME_WIDTH, width_data);
      write_register(CSR_FRAME_HEIGHT, height_data);
      write_register(CSR_PLANE_COUNT, planes_data);
      if (poke_spare) write_register(CSR_SPARE_INDEX, 16'($urandom));
      csr_valid <= 1'b0;
      frame_setups++;
   endtask

   task automatic send_pixel(input logic [7:0] value);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_value <= value;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   // Interior pixels cause no result of their own, so the pipeline is given
   // settle time after the last expected result before any register write.
   task automatic drain_results;
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (CONFIG_SETTLE) @(posedge clock);
   endtask

   task automatic stream_texture(input int count, input texture_type texture);
      for (int i = 0; i < count; i++) send_pixel(pick_pixel(texture));
      drain_results();
   endtask

   initial begin
      int          random_pixels;
      int          roll;
      int          count;
      int          image;
      logic [15:0] width_data;
      logic [15:0] height_data;
      logic [15:0] planes_data;
      int unsigned w_eff;
      int unsigned h_eff;
      int unsigned p_eff;
      texture_type texture;

      random_pixels = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (CONFIG_SETTLE) @(posedge clock);

      // Smallest frame with an interior: one median, the delayed median ahead
      // of the border pixel that completes it.
      program_frame(16'd3, 16'd3, 16'd1, 1'b0);
      foreach (CROSS_PATTERN[i]) send_pixel(CROSS_PATTERN[i]);
      drain_results();

      // Frame too small for any interior, zero planes read as one, and the
      // stream wraps into the next image.
      program_frame(16'd2, 16'd2, 16'd0, 1'b0);
      foreach (WALKING_ONES[i]) send_pixel(WALKING_ONES[i]);
      drain_results();

      // Zero width and height read as one; seven planes saturate to four.
      program_frame(16'hF000, 16'h0000, 16'hFFFF, 1'b1);
      foreach (PLANE_SAMPLES[i]) send_pixel(PLANE_SAMPLES[i]);
      drain_results();

      while (random_pixels < RANDOM_TARGET) begin
         if (random_pixels < RANDOM_TARGET / 3) begin
            snd_idle_pct = 28;
            rcv_idle_pct = 59;
         end else if (random_pixels < 2 * RANDOM_TARGET / 3) begin
            snd_idle_pct = 59;
            rcv_idle_pct = 28;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end

         roll = $urandom_range(99);
         if (roll < 12) w_eff = $urandom_range(2);
         else if (roll < 85) w_eff = $urandom_range(3, 8);
         else w_eff = $urandom_range(9, 20);
         h_eff = ($urandom_range(99) < 12) ? $urandom_range(2) : $urandom_range(3, 6);
         planes_data = {13'($urandom), 3'($urandom_range(7))};
         // Bits above the register width are ignored by the filter.
         width_data = {4'($urandom), 12'(w_eff)};
         height_data = 16'(h_eff);
         if (w_eff == 0) w_eff = 1;
         if (h_eff == 0) h_eff = 1;
         p_eff = (planes_data[2:0] == 0) ? 1 : (planes_data[2:0] > 4) ? 4 : planes_data[2:0];
         image = w_eff * h_eff * p_eff;

         roll = $urandom_range(99);
         if (roll < 70) count = image;
         else if (roll < 85) count = $urandom_range(1, image);
         else count = image + $urandom_range(1, 20);
         if (count > FRAME_CAP) count = FRAME_CAP;

         roll = $urandom_range(99);
         texture = (roll < 60) ? TEXTURE_NOISE :
                   (roll < 80) ? TEXTURE_FEW_LEVELS : TEXTURE_BLACK_WHITE;

         program_frame(width_data, height_data, planes_data, $urandom_range(9) == 0);
         stream_texture(count, texture);
         random_pixels += count;
      end

      // Tallest frame, cut short by the end of the run.
      program_frame(16'd3, 16'hFFFF, 16'd4, 1'b0);
      stream_texture(40, TEXTURE_NOISE);

      repeat (END_SETTLE) @(posedge clock);
      $display("Run covered %0d pixel requests over %0d frame setups, %0d results compared.",
               pixels_sent, frame_setups, results_checked);
      $display("Geometries ranged from single pixels to 20-pixel rows, with zero sizes and saturated plane counts.");
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
